[hw/rtl/espsa_pkg.sv]
// Shared types and constants for the ESP security association lookup block.
package espsa_pkg;

    localparam int MAX_ENTRIES  = 16;
    localparam int IDX_W        = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);
    localparam int HDR_BYTES    = 8;
    localparam int WINDOW_RESET = 64;

    typedef enum logic {
        FUNC_ADD = 1'b0,
        FUNC_PKT = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_SHORT   = 3'd2,
        ST_NOENTRY = 3'd3,
        ST_SEQZERO = 3'd4,
        ST_REPLAY  = 3'd5,
        ST_OLD     = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_SCAN,
        ENG_EVAL,
        ENG_DONE
    } t_eng_state;

    typedef struct packed {
        t_func       func;
        logic [31:0] spi;
        logic [31:0] seq;
        logic [15:0] pkt_bytes;
        logic [7:0]  enc_id;
        logic [7:0]  auth_id;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [3:0]  entry_index;
        logic [7:0]  cipher_id;
        logic [7:0]  integrity_id;
        logic [15:0] body_len;
    } t_result;

    typedef struct packed {
        logic [31:0] spi;
        logic [7:0]  cipher;
        logic [7:0]  integrity;
        logic [31:0] last_seq;
    } t_entry;

    typedef struct packed {
        logic busy;
        logic done;
    } t_eng_stat;

    // Low four bits of a table address, zero-extended when the address is narrower.
    function automatic logic [3:0] idx_out(input logic [IDX_W-1:0] addr);
        logic [IDX_W+3:0] w;
        w = {4'b0000, addr};
        return w[3:0];
    endfunction

endpackage

[hw/rtl/espsa_req_if.sv]
// Request channel: entry adds and packet headers.
interface espsa_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] spi;
    logic [31:0] seq;
    logic [15:0] pkt_bytes;
    logic [7:0]  enc_id;
    logic [7:0]  auth_id;

    modport source (
        output valid, func, spi, seq, pkt_bytes, enc_id, auth_id,
        input  ready
    );
    modport sink (
        input  valid, func, spi, seq, pkt_bytes, enc_id, auth_id,
        output ready
    );
endinterface

[hw/rtl/espsa_rsp_if.sv]
// Response channel: one result word per request word.
interface espsa_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [3:0]  entry_index;
    logic [7:0]  cipher_id;
    logic [7:0]  integrity_id;
    logic [15:0] body_len;

    modport source (
        output valid, status, entry_index, cipher_id, integrity_id, body_len,
        input  ready
    );
    modport sink (
        input  valid, status, entry_index, cipher_id, integrity_id, body_len,
        output ready
    );
endinterface

[hw/rtl/espsa_engine.sv]
// Table memory with the add, search and sequence check sequencer.
module espsa_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  espsa_pkg::t_item   i_item,
    input  logic [31:0]        i_window,
    input  logic               i_take,
    output espsa_pkg::t_eng_stat o_stat,
    output espsa_pkg::t_result o_res
);
    import espsa_pkg::*;

    t_eng_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_scan, n_scan;
    t_item   r_item, n_item;
    t_result r_res, n_res;

    t_entry           r_mem [MAX_ENTRIES];
    t_entry           r_rd;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;

    logic             hit;
    logic             last_entry;
    logic [CNT_W-1:0] scan_inc;
    logic [31:0]      seq_gap;

    assign hit        = (r_rd.spi == r_item.spi);
    assign scan_inc   = r_scan + CNT_W'(1);
    assign last_entry = (scan_inc >= r_count);
    assign seq_gap    = r_rd.last_seq - r_item.seq;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ENG_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
        r_item <= n_item;
        r_res  <= n_res;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ENG_IDLE: begin
                if (i_start) begin
                    if (i_item.func == FUNC_ADD) begin
                        n_state = ENG_DONE;
                    end else if (i_item.pkt_bytes < 16'(HDR_BYTES) || r_count == '0) begin
                        n_state = ENG_DONE;
                    end else begin
                        n_state = ENG_SCAN;
                    end
                end
            end
            ENG_SCAN: begin
                if (hit) begin
                    n_state = ENG_EVAL;
                end else if (last_entry) begin
                    n_state = ENG_DONE;
                end
            end
            ENG_EVAL: begin
                n_state = ENG_DONE;
            end
            ENG_DONE: begin
                if (i_take) begin
                    n_state = ENG_IDLE;
                end
            end
            default: n_state = ENG_IDLE;
        endcase
    end

    always_comb begin
        n_count = r_count;
        n_scan  = r_scan;
        n_item  = r_item;
        n_res   = r_res;
        rd_en   = 1'b0;
        rd_addr = r_scan[IDX_W-1:0];
        wr_en   = 1'b0;
        wr_addr = r_scan[IDX_W-1:0];
        wr_data = r_rd;
        unique case (r_state)
            ENG_IDLE: begin
                if (i_start) begin
                    n_item  = i_item;
                    n_scan  = '0;
                    rd_en   = 1'b1;
                    rd_addr = '0;
                    n_res   = '0;
                    if (i_item.func == FUNC_ADD) begin
                        if (r_count >= CNT_W'(MAX_ENTRIES)) begin
                            n_res.status = ST_FULL;
                        end else begin
                            wr_en             = 1'b1;
                            wr_addr           = r_count[IDX_W-1:0];
                            wr_data.spi       = i_item.spi;
                            wr_data.cipher    = i_item.enc_id;
                            wr_data.integrity = i_item.auth_id;
                            wr_data.last_seq  = '0;
                            n_count           = r_count + CNT_W'(1);
                            n_res.status      = ST_OK;
                            n_res.entry_index = idx_out(r_count[IDX_W-1:0]);
                        end
                    end else if (i_item.pkt_bytes < 16'(HDR_BYTES)) begin
                        n_res.status = ST_SHORT;
                    end else begin
                        n_res.status = ST_NOENTRY;
                    end
                end
            end
            ENG_SCAN: begin
                // The read data stays put while the match is evaluated.
                if (!hit) begin
                    n_scan  = scan_inc;
                    rd_en   = 1'b1;
                    rd_addr = scan_inc[IDX_W-1:0];
                end
            end
            ENG_EVAL: begin
                n_res.entry_index  = idx_out(r_scan[IDX_W-1:0]);
                n_res.cipher_id    = r_rd.cipher;
                n_res.integrity_id = r_rd.integrity;
                n_res.body_len     = '0;
                if (r_item.seq == '0) begin
                    n_res.status = ST_SEQZERO;
                end else if (r_item.seq <= r_rd.last_seq) begin
                    n_res.status = (seq_gap < i_window) ? ST_REPLAY : ST_OLD;
                end else begin
                    wr_en              = 1'b1;
                    wr_data.last_seq   = r_item.seq;
                    n_res.status       = ST_OK;
                    n_res.body_len     = r_item.pkt_bytes - 16'(HDR_BYTES);
                end
            end
            ENG_DONE: begin
            end
            default: begin
            end
        endcase
    end

    assign o_stat.busy = (r_state != ENG_IDLE);
    assign o_stat.done = (r_state == ENG_DONE);
    assign o_res       = r_res;

endmodule

[hw/rtl/esp_sa_lookup_replay_check.sv]
// Top level of the ESP security association lookup with anti-replay check.
//
// Request words on i_req either add a security association (func 0) or
// present a packet header (func 1). Each request word yields exactly one
// response word on o_rsp, in order. The user writes the replay window
// register through i_cfg_we / i_cfg_wdata only while the block is idle;
// the block itself does not enforce this.
//
// An add, a short packet or a packet met with an empty table goes straight
// from idle to the done state. Any other packet is searched for in the table
// from entry 0 until a match or the last filled entry; a match then passes
// through an evaluation state to check and write back the sequence number.
// The search reads one table entry per cycle from the table memory. The next
// request is taken once the previous response sits in the output register.
//
// Reset empties the table and sets the window to 64; the table memory is not
// cleared since only entries below the fill count are ever matched. A stalled
// receiver holds the response in the output register; the engine then keeps
// its finished result and takes no new request until the register frees.
module esp_sa_lookup_replay_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    espsa_req_if.sink   i_req,
    espsa_rsp_if.source o_rsp,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);
    import espsa_pkg::*;

    logic [31:0] r_window;
    logic        r_out_valid, n_out_valid;
    t_result     r_res;
    t_item       item;
    t_eng_stat   stat;
    t_result     eng_res;
    logic        start;
    logic        take;

    assign item.func      = t_func'(i_req.func);
    assign item.spi       = i_req.spi;
    assign item.seq       = i_req.seq;
    assign item.pkt_bytes = i_req.pkt_bytes;
    assign item.enc_id    = i_req.enc_id;
    assign item.auth_id   = i_req.auth_id;

    assign i_req.ready = !stat.busy;
    assign start       = i_req.valid && !stat.busy;
    assign take        = stat.done && (!r_out_valid || o_rsp.ready);

    espsa_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_item   (item),
        .i_window (r_window),
        .i_take   (take),
        .o_stat   (stat),
        .o_res    (eng_res)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (take) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= 32'(WINDOW_RESET);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= eng_res;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_res.status;
    assign o_rsp.entry_index  = r_res.entry_index;
    assign o_rsp.cipher_id    = r_res.cipher_id;
    assign o_rsp.integrity_id = r_res.integrity_id;
    assign o_rsp.body_len     = r_res.body_len;

    // An accepted request always occupies the engine in the next cycle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> stat.busy)
        else $error("engine not busy after a request was accepted");

    // A held response is never overwritten by the engine.
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_rsp.ready |=> r_out_valid && $stable(r_res))
        else $error("held response changed");

    // Only an accepted packet carries a payload length.
    a_payload_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.status != ST_OK |-> r_res.body_len == '0)
        else $error("payload length on a rejected word");

    // Table full, short packet and no-match words report no entry data.
    a_no_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_res.status == ST_FULL || r_res.status == ST_NOENTRY
            || r_res.status == ST_SHORT)
        |-> r_res.entry_index == '0 && r_res.cipher_id == '0
            && r_res.integrity_id == '0)
        else $error("entry data on a word without a matched entry");

endmodule
